>>> hdl/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table core.
// ----------------------------------------------------------------------------
`default_nettype none

package dvrt_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int NCNT_W    = 5;
  localparam int COST_W    = 16;
  localparam int TTL_W     = 17;
  localparam int HOP_W     = 5;
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // request kinds
  typedef enum logic [1:0] {
    FN_ENTRY = 2'd0,
    FN_END   = 2'd1,
    FN_TICK  = 2'd2,
    FN_INIT  = 2'd3
  } func_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NCNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD,
    ST_SETUP,
    ST_RP_LATCH,
    ST_RP_RUN,
    ST_RP_DRAIN,
    ST_RX_LATCH,
    ST_RX_RUN,
    ST_RX_DRAIN,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic              accept;
    logic              build_wr;
    logic              setup;
    logic              rp_latch;
    logic              rp_issue;
    logic              rx_latch;
    logic              rx_issue;
    logic              emit;
    logic [NODE_W-1:0] i;
    logic [NODE_W-1:0] j;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [NODE_W-1:0] n_m1;
    logic              end_ok;
    logic              tick_expire;
  } stat_t;

endpackage

`default_nettype wire

>>> hdl/dvrt_ctrl.sv
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Sequencer: walks build, repair, relaxation and emission loops.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [1:0]            in_func,
  input  wire dvrt_pkg::stat_t       stat,
  output dvrt_pkg::cmd_t             cmd,
  output logic                       busy
);

  dvrt_pkg::state_t state_r, state_nxt;
  logic [dvrt_pkg::NODE_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic accept;
  logic j_last, i_last;

  assign accept = start && (state_r == dvrt_pkg::ST_IDLE);
  assign j_last = (j_r == stat.n_m1);
  assign i_last = (i_r == stat.n_m1);

  // state and loop counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dvrt_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    case (state_r)
      dvrt_pkg::ST_IDLE: begin
        if (accept) begin
          case (dvrt_pkg::func_t'(in_func))
            dvrt_pkg::FN_END: begin
              if (stat.end_ok) state_nxt = dvrt_pkg::ST_RP_LATCH;
            end
            dvrt_pkg::FN_TICK: begin
              if (stat.tick_expire) begin
                state_nxt = dvrt_pkg::ST_EMIT;
                j_nxt     = '0;
              end
            end
            dvrt_pkg::FN_INIT: begin
              i_nxt = dvrt_pkg::NODE_W'(1);
              j_nxt = '0;
              if (stat.n_m1 == '0) state_nxt = dvrt_pkg::ST_SETUP;
              else                 state_nxt = dvrt_pkg::ST_BUILD;
            end
            default: ;
          endcase
        end
      end
      dvrt_pkg::ST_BUILD: begin
        if (j_last) begin
          j_nxt = '0;
          if (i_last) state_nxt = dvrt_pkg::ST_SETUP;
          else        i_nxt     = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      dvrt_pkg::ST_SETUP: begin
        state_nxt = dvrt_pkg::ST_RX_LATCH;
        i_nxt     = '0;
      end
      dvrt_pkg::ST_RP_LATCH: begin
        state_nxt = dvrt_pkg::ST_RP_RUN;
        j_nxt     = '0;
      end
      dvrt_pkg::ST_RP_RUN: begin
        if (j_last) state_nxt = dvrt_pkg::ST_RP_DRAIN;
        else        j_nxt     = j_r + 1'b1;
      end
      dvrt_pkg::ST_RP_DRAIN: begin
        state_nxt = dvrt_pkg::ST_RX_LATCH;
        i_nxt     = '0;
      end
      dvrt_pkg::ST_RX_LATCH: begin
        state_nxt = dvrt_pkg::ST_RX_RUN;
        j_nxt     = '0;
      end
      dvrt_pkg::ST_RX_RUN: begin
        if (j_last) state_nxt = dvrt_pkg::ST_RX_DRAIN;
        else        j_nxt     = j_r + 1'b1;
      end
      dvrt_pkg::ST_RX_DRAIN: begin
        if (i_last) begin
          state_nxt = dvrt_pkg::ST_EMIT;
          j_nxt     = '0;
        end else begin
          state_nxt = dvrt_pkg::ST_RX_LATCH;
          i_nxt     = i_r + 1'b1;
        end
      end
      dvrt_pkg::ST_EMIT: begin
        if (j_last) state_nxt = dvrt_pkg::ST_IDLE;
        else        j_nxt     = j_r + 1'b1;
      end
      default: state_nxt = dvrt_pkg::ST_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.i        = i_r;
    cmd.j        = j_r;
    cmd.accept   = accept;
    cmd.build_wr = (state_r == dvrt_pkg::ST_BUILD);
    cmd.setup    = (state_r == dvrt_pkg::ST_SETUP);
    cmd.rp_latch = (state_r == dvrt_pkg::ST_RP_LATCH);
    cmd.rp_issue = (state_r == dvrt_pkg::ST_RP_RUN);
    cmd.rx_latch = (state_r == dvrt_pkg::ST_RX_LATCH);
    cmd.rx_issue = (state_r == dvrt_pkg::ST_RX_RUN);
    cmd.emit     = (state_r == dvrt_pkg::ST_EMIT);
    busy         = (state_r != dvrt_pkg::ST_IDLE);
  end

endmodule

`default_nettype wire

>>> hdl/dvrt_dp.sv
// ----------------------------------------------------------------------------
// dvrt_dp
// Datapath: config registers, cost matrix memory, own-cost row, next hop
// and TTL registers, relax/repair compare unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire dvrt_pkg::cmd_t                    cmd,
  output dvrt_pkg::stat_t                        stat,
  input  wire logic [1:0]                        in_func,
  input  wire logic [3:0]                        in_from_node,
  input  wire logic [3:0]                        in_dest_node,
  input  wire logic [15:0]                       in_adv_cost,
  input  wire logic                              cfg_valid,
  input  wire logic [dvrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dvrt_pkg::CFG_W-1:0]        cfg_data,
  output logic                                   out_valid,
  output logic [3:0]                             out_route_dest,
  output logic signed [4:0]                      out_route_next_hop,
  output logic [15:0]                            out_route_cost,
  output logic signed [16:0]                     out_route_ttl,
  output logic                                   out_table_changed,
  output logic                                   out_last_row
);

  localparam int NW = dvrt_pkg::NODE_W;
  localparam int CW = dvrt_pkg::COST_W;
  localparam int TW = dvrt_pkg::TTL_W;
  localparam int HW = dvrt_pkg::HOP_W;

  // configuration
  logic [CW-1:0]                 inf_r;
  logic [15:0]                   ttl_rl_r;
  logic [dvrt_pkg::NCNT_W-1:0]   ncnt_r;
  logic [dvrt_pkg::MAX_NODES-1:0] nmask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inf_r    <= CW'(16);
      ttl_rl_r <= 16'd30;
      ncnt_r   <= dvrt_pkg::NCNT_W'(1);
      nmask_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dvrt_pkg::CFG_INF:  inf_r    <= cfg_data[CW-1:0];
        dvrt_pkg::CFG_TTL:  ttl_rl_r <= cfg_data;
        dvrt_pkg::CFG_NCNT: ncnt_r   <= cfg_data[dvrt_pkg::NCNT_W-1:0];
        dvrt_pkg::CFG_MASK: nmask_r  <= cfg_data[dvrt_pkg::MAX_NODES-1:0];
        default: ;
      endcase
    end
  end

  // clamp node count to 1..MAX_NODES, kept as count minus one
  logic [NW-1:0] n_m1;
  always_comb begin
    if (ncnt_r == '0)
      n_m1 = '0;
    else if (ncnt_r > dvrt_pkg::NCNT_W'(dvrt_pkg::MAX_NODES))
      n_m1 = NW'(dvrt_pkg::MAX_NODES - 1);
    else
      n_m1 = NW'(ncnt_r - 1'b1);
  end

  // state tables
  logic [CW-1:0]        row0_r [dvrt_pkg::MAX_NODES];
  logic signed [HW-1:0] nh_r   [dvrt_pkg::MAX_NODES];
  logic signed [TW-1:0] ttl_r  [dvrt_pkg::MAX_NODES];
  logic [CW-1:0]        mem    [dvrt_pkg::MAX_NODES * dvrt_pkg::MAX_NODES];

  logic [NW-1:0] via_r;
  logic [CW-1:0] base_r;
  logic [NW-1:0] p_i_r, p_j_r;
  logic          rp_v_r, rx_v_r;
  logic [CW-1:0] rd_r;
  logic          changed_r;

  logic entry_ok, end_ok, tick_expire;
  assign end_ok   = (in_from_node != '0) && (in_from_node <= n_m1);
  assign entry_ok = end_ok && (in_dest_node <= n_m1);

  always_comb begin
    tick_expire = 1'b0;
    for (int k = 1; k < dvrt_pkg::MAX_NODES; k++) begin
      if ((NW'(k) <= n_m1) && (ttl_r[k] == TW'(1))) tick_expire = 1'b1;
    end
  end

  assign stat.n_m1        = n_m1;
  assign stat.end_ok      = end_ok;
  assign stat.tick_expire = tick_expire;

  logic acc_entry, acc_end, acc_tick;
  assign acc_entry = cmd.accept && (dvrt_pkg::func_t'(in_func) == dvrt_pkg::FN_ENTRY);
  assign acc_end   = cmd.accept && (dvrt_pkg::func_t'(in_func) == dvrt_pkg::FN_END);
  assign acc_tick  = cmd.accept && (dvrt_pkg::func_t'(in_func) == dvrt_pkg::FN_TICK);

  // single read select on the own-cost row and next hop tables
  logic [NW-1:0]        rsel;
  logic [CW-1:0]        row0_rd;
  logic signed [HW-1:0] nh_rd;
  always_comb begin
    if (cmd.rx_latch)      rsel = cmd.i;
    else if (cmd.rp_latch) rsel = via_r;
    else if (cmd.emit)     rsel = cmd.j;
    else                   rsel = p_j_r;
  end
  assign row0_rd = row0_r[rsel];
  assign nh_rd   = nh_r[rsel];

  // matrix memory port
  logic [dvrt_pkg::ADDR_W-1:0] maddr;
  logic                        mwe;
  logic [CW-1:0]               mwd;
  always_comb begin
    mwe = 1'b0;
    mwd = inf_r;
    if (cmd.build_wr) begin
      maddr = {cmd.i, cmd.j};
      mwe   = 1'b1;
      mwd   = ((cmd.j == '0) && nmask_r[cmd.i]) ? CW'(1) : inf_r;
    end else if (cmd.rp_issue) begin
      maddr = {via_r, cmd.j};
    end else if (cmd.rx_issue) begin
      maddr = {cmd.i, cmd.j};
    end else begin
      maddr = {in_from_node, in_dest_node};
      mwe   = acc_entry && entry_ok;
      mwd   = in_adv_cost[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwd;
    rd_r <= mem[maddr];
  end

  // pipeline tags for the compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_v_r <= 1'b0;
      rx_v_r <= 1'b0;
    end else begin
      rp_v_r <= cmd.rp_issue;
      rx_v_r <= cmd.rx_issue;
    end
  end

  always_ff @(posedge clk) begin
    p_j_r <= cmd.j;
    p_i_r <= cmd.i;
    if (cmd.rx_latch || cmd.rp_latch) base_r <= row0_rd;
    if (acc_end && end_ok) via_r <= in_from_node;
  end

  // compare unit
  logic [CW:0]   sum_full;
  logic [CW-1:0] mat_v, rp_val;
  logic          rx_hit, rp_hit;
  always_comb begin
    mat_v    = (rx_v_r && (p_i_r == '0)) ? row0_rd : rd_r;
    sum_full = {1'b0, base_r} + {1'b0, mat_v};
    rx_hit   = rx_v_r && (sum_full < {1'b0, row0_rd});
    rp_hit   = rp_v_r && (nh_rd == HW'({1'b0, via_r})) && (via_r != p_j_r);
    if (rd_r == inf_r)       rp_val = inf_r;
    else if (sum_full[CW])   rp_val = '1;
    else                     rp_val = sum_full[CW-1:0];
  end

  // table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < dvrt_pkg::MAX_NODES; k++) begin
        nh_r[k]  <= '1;
        ttl_r[k] <= '1;
      end
      changed_r <= 1'b0;
    end else begin
      if (cmd.accept) changed_r <= 1'b0;
      if (acc_end && end_ok && nmask_r[in_from_node])
        ttl_r[in_from_node] <= TW'({1'b0, ttl_rl_r});
      if (acc_tick) begin
        for (int k = 1; k < dvrt_pkg::MAX_NODES; k++) begin
          if ((NW'(k) <= n_m1) && !ttl_r[k][TW-1] && (ttl_r[k] != '0)) begin
            ttl_r[k] <= ttl_r[k] - 1'b1;
            if (ttl_r[k] == TW'(1)) row0_r[k] <= inf_r;
          end
        end
      end
      if (cmd.setup) begin
        for (int k = 0; k < dvrt_pkg::MAX_NODES; k++) begin
          if (NW'(k) <= n_m1) begin
            if ((k == 0) || nmask_r[k]) begin
              row0_r[k] <= (k == 0) ? '0 : CW'(1);
              nh_r[k]   <= HW'(k);
              ttl_r[k]  <= TW'({1'b0, ttl_rl_r});
            end else begin
              row0_r[k] <= inf_r;
              nh_r[k]   <= '1;
              ttl_r[k]  <= '1;
            end
          end
        end
      end
      if (rp_hit) row0_r[p_j_r] <= rp_val;
      if (rx_hit) begin
        row0_r[p_j_r] <= sum_full[CW-1:0];
        nh_r[p_j_r]   <= HW'({1'b0, p_i_r});
        changed_r     <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      out_route_dest     <= cmd.j;
      out_route_next_hop <= nh_rd;
      out_route_cost     <= row0_rd;
      out_route_ttl      <= ttl_r[cmd.j];
      out_table_changed  <= changed_r;
      out_last_row       <= (cmd.j == n_m1);
    end
  end

endmodule

`default_nettype wire

>>> hdl/distance_vector_route_table_core.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_core
// Distance-vector route engine: cost matrix, next hops and neighbor TTLs,
// with route repair and an in-place Bellman-Ford relaxation pass.
//
//   channel   ports                          handshake
//   request   start, busy, in_*              start & !busy
//   result    out_valid, out_*               valid per row, no stall
//   config    cfg_valid, cfg_ready, cfg_*    cfg_valid & cfg_ready
//
// The relaxation loop reads the cost matrix one entry per cycle on the
// single memory port, with a latch and a drain state around each row.
// Reset is synchronous and returns all TTLs and next hops to -1.
// Results come one per cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_table_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_func,
  input  wire logic [3:0]                     in_from_node,
  input  wire logic [3:0]                     in_dest_node,
  input  wire logic [15:0]                    in_adv_cost,
  output logic                                out_valid,
  output logic [3:0]                          out_route_dest,
  output logic signed [4:0]                   out_route_next_hop,
  output logic [15:0]                         out_route_cost,
  output logic signed [16:0]                  out_route_ttl,
  output logic                                out_table_changed,
  output logic                                out_last_row,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dvrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dvrt_pkg::CFG_W-1:0]     cfg_data
);

  dvrt_pkg::cmd_t  cmd;
  dvrt_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  dvrt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  dvrt_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_func            (in_func),
    .in_from_node       (in_from_node),
    .in_dest_node       (in_dest_node),
    .in_adv_cost        (in_adv_cost),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_route_dest     (out_route_dest),
    .out_route_next_hop (out_route_next_hop),
    .out_route_cost     (out_route_cost),
    .out_route_ttl      (out_route_ttl),
    .out_table_changed  (out_table_changed),
    .out_last_row       (out_last_row)
  );

endmodule

`default_nettype wire
